// ===== rtl/core/artr_pkg.sv =====
package artr_pkg;

    // Field widths
    localparam int CW  = 20;          // coordinate, Q.4
    localparam int DW  = 21;          // segment difference
    localparam int SW  = 42;          // squared length
    localparam int RW  = 21;          // square root
    localparam int QW  = 16;          // quotient magnitude
    localparam int PW  = 16;          // pixel
    localparam int REMW = RW + 3;     // square-root partial remainder
    localparam int DREMW = RW + 1;    // divider partial remainder

    // Stage counts of the iterative units
    localparam int SQRT_LAT = RW;
    localparam int DIV_LAT  = QW;
    localparam int DLY      = SQRT_LAT + DIV_LAT;

    // Per-word side information that rides along with the arithmetic
    typedef struct packed {
        logic signed [DW-1:0] dx;
        logic signed [DW-1:0] dy;
        logic signed [CW-1:0] ex;
        logic signed [CW-1:0] ey;
        logic signed [CW-1:0] hx;
        logic signed [CW-1:0] hy;
        logic                 last;
        logic                 deg;
    } side_t;

endpackage

// ===== rtl/core/arrow_point_rotate_translate.sv =====
// Throughput: one word per cycle while the output is not stalled; the square
// root takes 21 stages (one root bit each) and the two dividers 16 stages
// (one quotient bit each).
// A stalled output holds the whole pipeline; no word is lost or repeated.
// Reset (rst_n low, asynchronous) clears all valid bits; data registers keep
// whatever they hold.
module arrow_point_rotate_translate
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic signed [artr_pkg::CW-1:0]  start_x,
    input  logic signed [artr_pkg::CW-1:0]  start_y,
    input  logic signed [artr_pkg::CW-1:0]  end_x,
    input  logic signed [artr_pkg::CW-1:0]  end_y,
    input  logic signed [artr_pkg::CW-1:0]  shape_x,
    input  logic signed [artr_pkg::CW-1:0]  shape_y,
    input  logic                            last_in,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic signed [artr_pkg::PW-1:0]  pixel_x,
    output logic signed [artr_pkg::PW-1:0]  pixel_y,
    output logic                            degenerate,
    output logic                            last_out
);

    logic en;

    logic              v1_reg, v2_reg;
    artr_pkg::side_t   sd1_reg, sd1_next;
    artr_pkg::side_t   sd2_reg;
    logic [artr_pkg::SW-1:0] s_reg;

    logic              vd_reg [0:artr_pkg::DLY-1];
    artr_pkg::side_t   sd_reg [0:artr_pkg::DLY-1];

    logic signed [2*artr_pkg::DW-1:0] sqx, sqy;
    logic [artr_pkg::RW-1:0] root;
    logic [artr_pkg::DW-1:0] adx, ady;
    logic [artr_pkg::QW-1:0] qc, qs;

    // Global advance: move unless a result sits stalled at the output
    assign en       = !(out_valid && out_stall);
    assign in_stall = out_valid && out_stall;

    // Stage 1: segment difference; zero length when start equals end
    always_comb
    begin
        sd1_next.dx   = artr_pkg::DW'(start_x) - artr_pkg::DW'(end_x);
        sd1_next.dy   = artr_pkg::DW'(start_y) - artr_pkg::DW'(end_y);
        sd1_next.ex   = end_x;
        sd1_next.ey   = end_y;
        sd1_next.hx   = shape_x;
        sd1_next.hy   = shape_y;
        sd1_next.last = last_in;
        sd1_next.deg  = (start_x == end_x) && (start_y == end_y);
    end

    // Stage 2: squared length
    assign sqx = (2*artr_pkg::DW)'(sd1_reg.dx) * (2*artr_pkg::DW)'(sd1_reg.dx);
    assign sqy = (2*artr_pkg::DW)'(sd1_reg.dy) * (2*artr_pkg::DW)'(sd1_reg.dy);

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            for (int i = 0; i < artr_pkg::DLY; i++)
            begin
                vd_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            v1_reg    <= in_valid;
            v2_reg    <= v1_reg;
            vd_reg[0] <= v2_reg;
            for (int i = 1; i < artr_pkg::DLY; i++)
            begin
                vd_reg[i] <= vd_reg[i-1];
            end
        end
    end

    // Payload of the front stages and side delay line
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sd1_reg     <= sd1_next;
            s_reg       <= artr_pkg::SW'($unsigned(sqx)) + artr_pkg::SW'($unsigned(sqy));
            sd2_reg     <= sd1_reg;
            sd_reg[0]   <= sd2_reg;
            for (int i = 1; i < artr_pkg::DLY; i++)
            begin
                sd_reg[i] <= sd_reg[i-1];
            end
        end
    end

    artr_isqrt u_isqrt
    (
        .clk  (clk),
        .en   (en),
        .rad  (s_reg),
        .root (root)
    );

    // Magnitudes of the differences at the square-root output
    assign adx = sd_reg[artr_pkg::SQRT_LAT-1].dx[artr_pkg::DW-1]
               ? artr_pkg::DW'(-sd_reg[artr_pkg::SQRT_LAT-1].dx)
               : artr_pkg::DW'(sd_reg[artr_pkg::SQRT_LAT-1].dx);
    assign ady = sd_reg[artr_pkg::SQRT_LAT-1].dy[artr_pkg::DW-1]
               ? artr_pkg::DW'(-sd_reg[artr_pkg::SQRT_LAT-1].dy)
               : artr_pkg::DW'(sd_reg[artr_pkg::SQRT_LAT-1].dy);

    artr_div u_div_cos
    (
        .clk (clk),
        .en  (en),
        .num (adx),
        .den (root),
        .quo (qc)
    );

    artr_div u_div_sin
    (
        .clk (clk),
        .en  (en),
        .num (ady),
        .den (root),
        .quo (qs)
    );

    artr_rot u_rot
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .in_vld     (vd_reg[artr_pkg::DLY-1]),
        .qc         (qc),
        .qs         (qs),
        .sd         (sd_reg[artr_pkg::DLY-1]),
        .out_vld    (out_valid),
        .pixel_x    (pixel_x),
        .pixel_y    (pixel_y),
        .degenerate (degenerate),
        .last_out   (last_out)
    );

`ifndef SYNTHESIS
    // A nonzero segment always yields a nonzero root
    a_root_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        vd_reg[artr_pkg::SQRT_LAT-1] && !sd_reg[artr_pkg::SQRT_LAT-1].deg |-> root != '0)
        else $error("zero root for nonzero segment");

    // Direction quotients never exceed one
    a_quo_range: assert property (@(posedge clk) disable iff (!rst_n)
        vd_reg[artr_pkg::DLY-1] && !sd_reg[artr_pkg::DLY-1].deg
        |-> qc <= 16'd32768 && qs <= 16'd32768)
        else $error("direction quotient above one");

    // An accepted word enters the first stage
    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> v1_reg)
        else $error("accepted word dropped");
`endif

endmodule

// ===== rtl/core/artr_isqrt.sv =====
module artr_isqrt
(
    input  logic                     clk,
    input  logic                     en,
    input  logic [artr_pkg::SW-1:0] rad,
    output logic [artr_pkg::RW-1:0] root
);

    logic [artr_pkg::REMW-1:0] rem_reg  [0:artr_pkg::SQRT_LAT-1];
    logic [artr_pkg::RW-1:0]   root_reg [0:artr_pkg::SQRT_LAT-1];
    logic [artr_pkg::SW-1:0]   rad_reg  [0:artr_pkg::SQRT_LAT-1];

    // One result bit per stage, two radicand bits consumed per stage
    for (genvar k = 0; k < artr_pkg::SQRT_LAT; k++)
    begin : g_stage
        logic [artr_pkg::REMW-1:0] rem_in;
        logic [artr_pkg::RW-1:0]   root_in;
        logic [artr_pkg::SW-1:0]   rad_in;
        logic [artr_pkg::REMW-1:0] cur;
        logic [artr_pkg::REMW-1:0] trial;

        if (k == 0)
        begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign rad_in  = rad;
        end
        else
        begin : g_next
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
            assign rad_in  = rad_reg[k-1];
        end

        assign cur   = {rem_in[artr_pkg::REMW-3:0], rad_in[artr_pkg::SW-1 -: 2]};
        assign trial = {1'b0, root_in, 2'b01};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (cur >= trial)
                begin
                    rem_reg[k]  <= cur - trial;
                    root_reg[k] <= {root_in[artr_pkg::RW-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[k]  <= cur;
                    root_reg[k] <= {root_in[artr_pkg::RW-2:0], 1'b0};
                end
                rad_reg[k] <= {rad_in[artr_pkg::SW-3:0], 2'b00};
            end
        end
    end

    assign root = root_reg[artr_pkg::SQRT_LAT-1];

endmodule

// ===== rtl/core/artr_div.sv =====
module artr_div
(
    input  logic                     clk,
    input  logic                     en,
    input  logic [artr_pkg::DW-1:0]  num,
    input  logic [artr_pkg::RW-1:0]  den,
    output logic [artr_pkg::QW-1:0]  quo
);

    // Computes floor((num << 15) / den); num <= den keeps the quotient in 16 bits
    logic [artr_pkg::DREMW-1:0] r_reg   [0:artr_pkg::DIV_LAT-1];
    logic [artr_pkg::QW-1:0]    n_reg   [0:artr_pkg::DIV_LAT-1];
    logic [artr_pkg::QW-1:0]    q_reg   [0:artr_pkg::DIV_LAT-1];
    logic [artr_pkg::RW-1:0]    den_reg [0:artr_pkg::DIV_LAT-1];

    // Restoring division, one quotient bit per stage
    for (genvar k = 0; k < artr_pkg::DIV_LAT; k++)
    begin : g_stage
        logic [artr_pkg::DREMW-1:0] r_in;
        logic [artr_pkg::QW-1:0]    n_in;
        logic [artr_pkg::QW-1:0]    q_in;
        logic [artr_pkg::RW-1:0]    d_in;
        logic [artr_pkg::DREMW-1:0] cur;

        if (k == 0)
        begin : g_first
            assign r_in = artr_pkg::DREMW'(num[artr_pkg::DW-1:1]);
            assign n_in = {num[0], {(artr_pkg::QW-1){1'b0}}};
            assign q_in = '0;
            assign d_in = den;
        end
        else
        begin : g_next
            assign r_in = r_reg[k-1];
            assign n_in = n_reg[k-1];
            assign q_in = q_reg[k-1];
            assign d_in = den_reg[k-1];
        end

        assign cur = {r_in[artr_pkg::DREMW-2:0], n_in[artr_pkg::QW-1]};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (cur >= {1'b0, d_in})
                begin
                    r_reg[k] <= cur - {1'b0, d_in};
                    q_reg[k] <= {q_in[artr_pkg::QW-2:0], 1'b1};
                end
                else
                begin
                    r_reg[k] <= cur;
                    q_reg[k] <= {q_in[artr_pkg::QW-2:0], 1'b0};
                end
                n_reg[k]   <= {n_in[artr_pkg::QW-2:0], 1'b0};
                den_reg[k] <= d_in;
            end
        end
    end

    assign quo = q_reg[artr_pkg::DIV_LAT-1];

endmodule

// ===== rtl/core/artr_rot.sv =====
module artr_rot
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            en,
    input  logic                            in_vld,
    input  logic [artr_pkg::QW-1:0]         qc,
    input  logic [artr_pkg::QW-1:0]         qs,
    input  artr_pkg::side_t                 sd,
    output logic                            out_vld,
    output logic signed [artr_pkg::PW-1:0]  pixel_x,
    output logic signed [artr_pkg::PW-1:0]  pixel_y,
    output logic                            degenerate,
    output logic                            last_out
);

    localparam int MW = artr_pkg::CW + artr_pkg::QW;   // product width
    localparam int AW = MW + 2;                        // sum width
    localparam int FB = 19;                            // fraction bits of the sum

    logic [2:0] v_reg;

    logic signed [artr_pkg::QW-1:0] c_reg, s_reg;
    logic signed [artr_pkg::CW-1:0] ex1_reg, ey1_reg, hx1_reg, hy1_reg;
    logic                           last1_reg, deg1_reg;

    logic signed [MW-1:0]           pxc_reg, pys_reg, pxs_reg, pyc_reg;
    logic signed [artr_pkg::CW-1:0] ex2_reg, ey2_reg;
    logic                           last2_reg, deg2_reg;

    logic signed [AW-1:0]           px_reg, py_reg;
    logic                           last3_reg, deg3_reg;

    logic signed [artr_pkg::QW-1:0] c_next, s_next;

    // Signed Q1.15 from quotient magnitude; +1.0 clips, degenerate forces zero
    function automatic logic signed [artr_pkg::QW-1:0] trig(
        input logic [artr_pkg::QW-1:0] q,
        input logic                    neg,
        input logic                    deg
    );
        logic [artr_pkg::QW:0] mag;
        mag = {1'b0, q};
        if (deg)
            return '0;
        else if (neg)
            return artr_pkg::QW'(-mag);
        else if (q[artr_pkg::QW-1])
            return {1'b0, {(artr_pkg::QW-1){1'b1}}};
        else
            return q;
    endfunction

    // Truncate toward zero to whole pixels, then clip to 16 bits
    function automatic logic signed [artr_pkg::PW-1:0] pix(input logic signed [AW-1:0] v);
        logic signed [AW-1:0]    t;
        logic signed [AW-FB-1:0] w;
        t = v + (v[AW-1] ? AW'((1 << FB) - 1) : AW'(0));
        w = t[AW-1:FB];
        if (w > (AW-FB)'(32767))
            return {1'b0, {(artr_pkg::PW-1){1'b1}}};
        else if (w < -(AW-FB)'(32768))
            return {1'b1, {(artr_pkg::PW-1){1'b0}}};
        else
            return w[artr_pkg::PW-1:0];
    endfunction

    assign c_next = trig(qc, sd.dx[artr_pkg::DW-1], sd.deg);
    assign s_next = trig(qs, sd.dy[artr_pkg::DW-1], sd.deg);

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg   <= '0;
            out_vld <= 1'b0;
        end
        else if (en)
        begin
            v_reg   <= {v_reg[1:0], in_vld};
            out_vld <= v_reg[2];
        end
    end

    // Data path: sign, products, sums, pixel
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_reg     <= c_next;
            s_reg     <= s_next;
            ex1_reg   <= sd.ex;
            ey1_reg   <= sd.ey;
            hx1_reg   <= sd.hx;
            hy1_reg   <= sd.hy;
            last1_reg <= sd.last;
            deg1_reg  <= sd.deg;

            pxc_reg   <= MW'(hx1_reg) * MW'(c_reg);
            pys_reg   <= MW'(hy1_reg) * MW'(s_reg);
            pxs_reg   <= MW'(hx1_reg) * MW'(s_reg);
            pyc_reg   <= MW'(hy1_reg) * MW'(c_reg);
            ex2_reg   <= ex1_reg;
            ey2_reg   <= ey1_reg;
            last2_reg <= last1_reg;
            deg2_reg  <= deg1_reg;

            px_reg    <= AW'(pxc_reg) - AW'(pys_reg) + (AW'(ex2_reg) <<< 15);
            py_reg    <= AW'(pxs_reg) + AW'(pyc_reg) + (AW'(ey2_reg) <<< 15);
            last3_reg <= last2_reg;
            deg3_reg  <= deg2_reg;

            pixel_x    <= pix(px_reg);
            pixel_y    <= pix(py_reg);
            last_out   <= last3_reg;
            degenerate <= deg3_reg;
        end
    end

endmodule
